/* hdl/ffba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Default table shape
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;
   localparam int MAX_PROCS_DEF  = 16;

   // Fixed field widths of the request and response beats
   localparam int INDEX_W    = 4;
   localparam int REQ_SIZE_W = 16;
   localparam int PID_W      = 5;
   localparam int NUMBER_W   = 5;
   localparam int LEFT_OUT_W = 16;
   localparam int TOTAL_W    = 20;
   localparam int BLOCKS_W   = 5;

   // Packed beat widths, padded to whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

   // Command codes carried on req_tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Sequencer controls for the scan unit
   typedef struct packed {
      logic clear;      // start of a new command: zero totals and match
      logic step;       // one table entry is on the read port
      logic allow_fit;  // a valid allocate is in progress
   } scan_ctrl_type;

endpackage

/* hdl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of fixed-size memory blocks, with running
// internal and external fragmentation totals.
// ----------------------------------------------------------------------------
// One command is handled at a time: a beat is accepted, then the sequencer
// walks the blocks in use one per cycle through the table read port and the
// shared compare/accumulate unit, then writes back and presents the response.
// A load first writes its table entry in a separate write state before the
// walk; an allocate goes straight to the walk. The walk covers the block
// count, capped at the table depth. A new request is taken while the previous
// response still waits in the output register; its own response then waits in
// the commit state until that beat is taken. The table needs no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF,
   parameter int MAX_PROCS  = ffba_pkg::MAX_PROCS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] block_index, [19:4] size_value, [24:20] process_id
   input  logic [ffba_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] command
   input  logic                               req_tuser,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] block_number, [20:5] leftover, [40:21] internal_total,
   // [60:41] external_total
   output logic [ffba_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration: blocks_in_use
   input  logic                               csr_wr_en,
   input  logic [ffba_pkg::BLOCKS_W-1:0]      csr_wr_data
);

   localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int XW  = (AW > ffba_pkg::INDEX_W) ? AW : ffba_pkg::INDEX_W;
   localparam int PW  = 8;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WRITE  = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [ffba_pkg::BLOCKS_W-1:0]    blocks_ff;
   logic                             cmd_ff;
   logic [ffba_pkg::INDEX_W-1:0]     idx_ff;
   logic                             idx_ok_ff;
   logic [SIZE_BITS-1:0]             size_ff;
   logic [ffba_pkg::PID_W-1:0]       pid_ff;
   logic                             pid_ok_ff;
   logic [CW-1:0]                    n_ff;
   logic [CW-1:0]                    cnt_ff;
   logic                             proc_valid_ff;
   logic [AW-1:0]                    proc_idx_ff;
   logic                             rsp_valid_ff;
   logic [ffba_pkg::RSP_DATA_W-1:0]  rsp_data_ff;

   logic [ffba_pkg::INDEX_W-1:0]     req_index;
   logic [ffba_pkg::REQ_SIZE_W-1:0]  req_size;
   logic [ffba_pkg::PID_W-1:0]       req_pid;
   logic                             req_fire;
   logic                             pid_ok_in;
   logic                             idx_ok_in;
   logic [CW-1:0]                    n_in;
   logic                             issue;
   logic                             scan_done;
   logic                             rsp_free;
   logic                             commit;
   logic [XW-1:0]                    idx_ext;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [SIZE_BITS-1:0]             wr_size;
   logic [ffba_pkg::PID_W-1:0]       wr_owner;
   logic [SIZE_BITS-1:0]             wr_left;
   logic [SIZE_BITS-1:0]             rd_size;
   logic [ffba_pkg::PID_W-1:0]       rd_owner;
   logic [SIZE_BITS-1:0]             rd_left;

   ffba_pkg::scan_ctrl_type          scan_ctrl;
   logic                             found;
   logic [AW-1:0]                    found_idx;
   logic [SIZE_BITS-1:0]             found_size;
   logic [SIZE_BITS-1:0]             found_left;
   logic [ffba_pkg::TOTAL_W-1:0]     internal_total;
   logic [ffba_pkg::TOTAL_W-1:0]     external_total;
   logic [AW:0]                      number_wide;
   logic [ffba_pkg::NUMBER_W-1:0]    number;
   logic [ffba_pkg::LEFT_OUT_W-1:0]  left_out;

   // Unpack the request beat
   assign req_index = req_tdata[3:0];
   assign req_size  = req_tdata[19:4];
   assign req_pid   = req_tdata[24:20];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Decode request checks and the clamped block count
   always_comb begin
      pid_ok_in = (req_pid != '0) && ({3'b000, req_pid} <= PW'(MAX_PROCS));
      idx_ok_in = ({4'b0000, req_index} < PW'(MAX_BLOCKS));
      if ({3'b000, blocks_ff} > PW'(MAX_BLOCKS)) begin
         n_in = CW'(MAX_BLOCKS);
      end else begin
         n_in = CW'(blocks_ff);
      end
   end

   // Hold the block count register
   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= ffba_pkg::BLOCKS_RESET;
      end else if (csr_wr_en) begin
         blocks_ff <= csr_wr_data;
      end
   end

   // Capture the command
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_tuser;
         idx_ff    <= req_index;
         idx_ok_ff <= idx_ok_in;
         size_ff   <= SIZE_BITS'(req_size);
         pid_ff    <= req_pid;
         pid_ok_ff <= pid_ok_in;
         n_ff      <= n_in;
      end
   end

   // Scan control
   assign issue     = (state_ff == S_SCAN) && (cnt_ff < n_ff);
   assign scan_done = (state_ff == S_SCAN) && !issue && !proc_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign commit    = (state_ff == S_COMMIT) && rsp_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == ffba_pkg::CMD_LOAD) ? S_WRITE : S_SCAN;
            end
         end
         S_WRITE: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance the sequencer and the read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         proc_valid_ff <= issue;
         if (req_fire) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= cnt_ff[AW-1:0];
   end

   // Table write port: load in S_WRITE, allocation write-back on commit
   assign idx_ext = XW'(idx_ff);
   always_comb begin
      if (state_ff == S_WRITE) begin
         wr_en    = (cmd_ff == ffba_pkg::CMD_LOAD) && idx_ok_ff;
         wr_addr  = idx_ext[AW-1:0];
         wr_size  = size_ff;
         wr_owner = '0;
         wr_left  = '0;
      end else begin
         wr_en    = commit && found;
         wr_addr  = found_idx;
         wr_size  = found_size;
         wr_owner = pid_ff;
         wr_left  = found_left;
      end
   end

   ffba_table #(
      .DEPTH     (MAX_BLOCKS),
      .SIZE_BITS (SIZE_BITS),
      .AW        (AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_size  (wr_size),
      .wr_owner (wr_owner),
      .wr_left  (wr_left),
      .rd_addr  (cnt_ff[AW-1:0]),
      .rd_size  (rd_size),
      .rd_owner (rd_owner),
      .rd_left  (rd_left)
   );

   assign scan_ctrl.clear     = req_fire;
   assign scan_ctrl.step      = proc_valid_ff;
   assign scan_ctrl.allow_fit = (cmd_ff == ffba_pkg::CMD_ALLOC) && pid_ok_ff;

   ffba_scan_unit #(
      .SIZE_BITS (SIZE_BITS),
      .AW        (AW)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (scan_ctrl),
      .entry_size     (rd_size),
      .entry_owner    (rd_owner),
      .entry_left     (rd_left),
      .entry_idx      (proc_idx_ff),
      .req_size       (size_ff),
      .found          (found),
      .found_idx      (found_idx),
      .found_size     (found_size),
      .found_left     (found_left),
      .internal_total (internal_total),
      .external_total (external_total)
   );

   // Build the response fields
   always_comb begin
      number_wide = {1'b0, found_idx} + 1'b1;
      number      = found ? ffba_pkg::NUMBER_W'(number_wide) : '0;
      left_out    = found ? ffba_pkg::LEFT_OUT_W'(found_left) : '0;
   end

   // Hold the response beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= {3'b000, external_total, internal_total, left_out, number};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after accepting a request");

   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff <= n_ff))
      else $error("scan counter ran past the blocks in use");

   a_match_needs_alloc : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && found) |-> (cmd_ff == ffba_pkg::CMD_ALLOC && pid_ok_ff))
      else $error("block matched without a valid allocate");

   a_left_fits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && found) |-> (found_left <= found_size))
      else $error("leftover exceeds chosen block size");
`endif

endmodule

/* hdl/ffba_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: size, owner and leftover per block, one write port and
// one registered read port. Entries never written read as a free empty block.
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int DEPTH     = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF,
   parameter int AW        = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [SIZE_BITS-1:0]         wr_size,
   input  logic [ffba_pkg::PID_W-1:0]   wr_owner,
   input  logic [SIZE_BITS-1:0]         wr_left,
   input  logic [AW-1:0]                rd_addr,
   output logic [SIZE_BITS-1:0]         rd_size,
   output logic [ffba_pkg::PID_W-1:0]   rd_owner,
   output logic [SIZE_BITS-1:0]         rd_left
);

   localparam int WORD_W = 2 * SIZE_BITS + ffba_pkg::PID_W;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   // Write and read the table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_size, wr_owner, wr_left};
      end
      rd_word_ff <= mem_ff[rd_addr];
   end

   // Track which entries hold written data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Unwritten entries read as zero size, free, no leftover
   assign rd_size  = rd_valid_ff ? rd_word_ff[WORD_W-1 -: SIZE_BITS] : '0;
   assign rd_owner = rd_valid_ff ? rd_word_ff[SIZE_BITS +: ffba_pkg::PID_W] : '0;
   assign rd_left  = rd_valid_ff ? rd_word_ff[SIZE_BITS-1:0] : '0;

endmodule

/* hdl/ffba_scan_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_scan_unit
// Shared compare/subtract and accumulate unit. Takes one table entry per
// step, picks the first free block that fits and keeps both running totals.
// ----------------------------------------------------------------------------
module ffba_scan_unit #(
   parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF,
   parameter int AW        = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffba_pkg::scan_ctrl_type        ctrl,
   input  logic [SIZE_BITS-1:0]           entry_size,
   input  logic [ffba_pkg::PID_W-1:0]     entry_owner,
   input  logic [SIZE_BITS-1:0]           entry_left,
   input  logic [AW-1:0]                  entry_idx,
   input  logic [SIZE_BITS-1:0]           req_size,
   output logic                           found,
   output logic [AW-1:0]                  found_idx,
   output logic [SIZE_BITS-1:0]           found_size,
   output logic [SIZE_BITS-1:0]           found_left,
   output logic [ffba_pkg::TOTAL_W-1:0]   internal_total,
   output logic [ffba_pkg::TOTAL_W-1:0]   external_total
);

   logic                          found_ff;
   logic [AW-1:0]                 found_idx_ff;
   logic [SIZE_BITS-1:0]          found_size_ff;
   logic [SIZE_BITS-1:0]          found_left_ff;
   logic [ffba_pkg::TOTAL_W-1:0]  internal_ff;
   logic [ffba_pkg::TOTAL_W-1:0]  external_ff;

   logic [SIZE_BITS:0]            diff;
   logic                          is_free;
   logic                          take;
   logic                          to_internal;
   logic [SIZE_BITS-1:0]          addend;
   logic [ffba_pkg::TOTAL_W-1:0]  acc_sel;
   logic [ffba_pkg::TOTAL_W-1:0]  acc_sum;

   // Compare by subtraction: no borrow means the block is big enough
   always_comb begin
      diff        = {1'b0, entry_size} - {1'b0, req_size};
      is_free     = (entry_owner == '0);
      take        = ctrl.allow_fit && !found_ff && is_free && !diff[SIZE_BITS];
      to_internal = take || !is_free;
      if (take) begin
         addend = diff[SIZE_BITS-1:0];
      end else if (is_free) begin
         addend = entry_size;
      end else begin
         addend = entry_left;
      end
      acc_sel = to_internal ? internal_ff : external_ff;
      acc_sum = acc_sel + ffba_pkg::TOTAL_W'(addend);
   end

   // Hold the match flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (ctrl.step && take) begin
         found_ff <= 1'b1;
      end
   end

   // Accumulate totals and capture the chosen block
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         internal_ff <= '0;
         external_ff <= '0;
      end else if (ctrl.step) begin
         if (to_internal) begin
            internal_ff <= acc_sum;
         end else begin
            external_ff <= acc_sum;
         end
         if (take) begin
            found_idx_ff  <= entry_idx;
            found_size_ff <= entry_size;
            found_left_ff <= diff[SIZE_BITS-1:0];
         end
      end
   end

   assign found          = found_ff;
   assign found_idx      = found_idx_ff;
   assign found_size     = found_size_ff;
   assign found_left     = found_left_ff;
   assign internal_total = internal_ff;
   assign external_total = external_ff;

endmodule
